### rtl/core/lgs_pkg.sv
// Shared types, constants and command structs for the launch grid statistics block.
`default_nettype none
package lgs_pkg;

  localparam int MAX_OPS   = 1024;
  localparam int CNT_W     = 11;
  localparam int CNT_CAP_I = (MAX_OPS < 2047) ? MAX_OPS : 2047;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

  // Shared divider: widest operand is worst_blocks * cost_sum (16 + 42 bits).
  localparam int DIV_W     = 58;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_NUM_SMS  = 3'd0,
    REG_MAX_BLK  = 3'd1,
    REG_SHARED   = 3'd2,
    REG_STATIC   = 3'd3,
    REG_SKEW_THR = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] num_sms;
    logic [6:0]  max_blk;
    logic [17:0] shared_sm;
    logic [15:0] static_sh;
    logic [15:0] skew_thr;
  } cfg_t;

  typedef enum logic [1:0] {
    DSEL_OCC  = 2'd0,
    DSEL_BEST = 2'd1,
    DSEL_SKEW = 2'd2,
    DSEL_POIS = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul;
    logic     upd;
    logic     div_start;
    logic     div_store;
    div_sel_t sel;
    logic     tgt;
    logic     mul1;
    logic     mul2;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/lgs_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lgs_div
  import lgs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DIV_W-1:0] den,
  output logic                  done,
  output logic      [DIV_W-1:0] quo
);

  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [DIV_W-1:0]     den_r;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 qbit;

  always_comb begin
    trial   = {rem_r, num_r[DIV_W-1]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    num_nxt = {num_r[DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

### rtl/core/lgs_ctrl.sv
// Sequencer for per-transaction accumulation and the end-of-step calculations.
`default_nettype none
module lgs_ctrl
  import lgs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_UPD,
    S_OCC_GO, S_OCC_WAIT, S_BEST_GO, S_BEST_WAIT,
    S_TGT, S_MUL1, S_MUL2,
    S_SKEW_GO, S_SKEW_WAIT, S_POIS_GO, S_POIS_WAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = DSEL_OCC;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last ? S_OCC_GO : S_IDLE;
      end
      S_OCC_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_OCC_WAIT;
      end
      S_OCC_WAIT: begin
        cmd.div_store = sts.div_done;
        if (sts.div_done) state_nxt = S_BEST_GO;
      end
      S_BEST_GO: begin
        cmd.sel       = DSEL_BEST;
        cmd.div_start = 1'b1;
        state_nxt     = S_BEST_WAIT;
      end
      S_BEST_WAIT: begin
        cmd.sel       = DSEL_BEST;
        cmd.div_store = sts.div_done;
        if (sts.div_done) state_nxt = S_TGT;
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SKEW_GO;
      end
      S_SKEW_GO: begin
        cmd.sel       = DSEL_SKEW;
        cmd.div_start = 1'b1;
        state_nxt     = S_SKEW_WAIT;
      end
      S_SKEW_WAIT: begin
        cmd.sel       = DSEL_SKEW;
        cmd.div_store = sts.div_done;
        if (sts.div_done) state_nxt = S_POIS_GO;
      end
      S_POIS_GO: begin
        cmd.sel       = DSEL_POIS;
        cmd.div_start = 1'b1;
        state_nxt     = S_POIS_WAIT;
      end
      S_POIS_WAIT: begin
        cmd.sel       = DSEL_POIS;
        cmd.div_store = sts.div_done;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the result
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

### rtl/core/lgs_dp.sv
// Datapath: step accumulators, end-of-step arithmetic and the result register.
`default_nettype none
module lgs_dp
  import lgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [31:0] in_op_cost,
  input  wire logic [17:0] in_shared_need,
  input  wire logic [15:0] in_block_cap,
  input  wire logic [15:0] in_assigned_blocks,
  input  wire logic        in_last_op,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      out_op_total,
  output logic [25:0]      out_blocks_total,
  output logic [6:0]       out_step_occupancy,
  output logic [6:0]       out_best_occupancy,
  output logic [16:0]      out_target_block_count,
  output logic [10:0]      out_starved_count,
  output logic [15:0]      out_skew_ratio,
  output logic [15:0]      out_poison_share,
  output logic             out_advise_partition
);

  // latched transaction
  logic [31:0] cost_r;
  logic [17:0] need_r;
  logic [15:0] cap_r;
  logic [15:0] blk_r;
  logic        last_r;

  logic [47:0] prod_a_r, prod_b_r;

  // step state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [41:0]      cost_sum_r, cost_sum_nxt;
  logic [25:0]      block_sum_r, block_sum_nxt;
  logic [17:0]      largest_r, largest_nxt;
  logic [17:0]      smallest_r, smallest_nxt;
  logic [41:0]      heavy_r, heavy_nxt;
  logic [31:0]      worst_cost_r, worst_cost_nxt;
  logic [15:0]      worst_blk_r, worst_blk_nxt;
  logic [CNT_W-1:0] starved_r, starved_nxt;

  // end-of-step values
  logic [6:0]  occ_r, best_r;
  logic [16:0] tgt_r;
  logic [48:0] skew_num_r;
  logic [36:0] den_lo_r, den_hi_r;
  logic [15:0] skew_r, pois_r;
  logic        pois_low_r;

  logic             out_valid_r;
  logic [10:0]      op_total_r, starved_out_r;
  logic [25:0]      blocks_out_r;
  logic [6:0]       occ_out_r, best_out_r;
  logic [16:0]      tgt_out_r;
  logic [15:0]      skew_out_r, pois_out_r;
  logic             advise_r;

  logic [DIV_W-1:0] div_num, div_den, div_quo;
  logic             div_done;

  logic [42:0] cost_add, heavy_add;
  logic [26:0] blk_add;
  logic [6:0]  per;
  logic [6:0]  mb1;
  logic [10:0] sms1;
  logic [17:0] tgt_prod;
  logic [DIV_W-1:0] quo_sat_chk;
  logic        advise_c;

  lgs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (cmd.sel)
      DSEL_OCC: begin
        div_num = DIV_W'(cfg.shared_sm);
        div_den = DIV_W'({1'b0, largest_r} + {3'b0, cfg.static_sh});
      end
      DSEL_BEST: begin
        div_num = DIV_W'(cfg.shared_sm);
        div_den = DIV_W'({1'b0, smallest_r} + {3'b0, cfg.static_sh});
      end
      DSEL_SKEW: begin
        div_num = DIV_W'({skew_num_r, 8'b0});
        div_den = DIV_W'(den_lo_r) + {den_hi_r, 21'b0};
      end
      DSEL_POIS: begin
        div_num = {heavy_r, 16'b0};
        div_den = DIV_W'(cost_sum_r);
      end
      default: ;
    endcase
  end

  // accumulate one transaction
  always_comb begin
    cost_add  = {1'b0, cost_sum_r} + 43'(cost_r);
    heavy_add = {1'b0, heavy_r} + 43'(cost_r);
    blk_add   = {1'b0, block_sum_r} + 27'(blk_r);

    count_nxt     = (count_r < CNT_CAP) ? count_r + 1'b1 : count_r;
    cost_sum_nxt  = cost_add[42] ? '1 : cost_add[41:0];
    block_sum_nxt = blk_add[26] ? '1 : blk_add[25:0];

    worst_cost_nxt = worst_cost_r;
    worst_blk_nxt  = worst_blk_r;
    if (blk_r != 16'd0 && prod_a_r > prod_b_r) begin
      worst_cost_nxt = cost_r;
      worst_blk_nxt  = blk_r;
    end

    starved_nxt = starved_r;
    if (blk_r == 16'd1 && cap_r > 16'd1 && starved_r < CNT_CAP)
      starved_nxt = starved_r + 1'b1;

    largest_nxt = largest_r;
    heavy_nxt   = heavy_r;
    priority if (need_r > largest_r) begin
      largest_nxt = need_r;
      heavy_nxt   = 42'(cost_r);
    end else if (need_r == largest_r && largest_r != 18'd0) begin
      heavy_nxt = heavy_add[42] ? '1 : heavy_add[41:0];
    end

    smallest_nxt = (need_r < smallest_r) ? need_r : smallest_r;
  end

  // blocks per multiprocessor from the divider quotient
  always_comb begin
    mb1 = (cfg.max_blk == 7'd0) ? 7'd1 : cfg.max_blk;
    per = mb1;
    if (((cmd.sel == DSEL_OCC) ? (largest_r != 18'd0) : (smallest_r != 18'd0))
        && cfg.shared_sm != 18'd0) begin
      if (div_quo < DIV_W'(mb1)) per = div_quo[6:0];
      if (per == 7'd0) per = 7'd1;
    end
    sms1        = (cfg.num_sms == 11'd0) ? 11'd1 : cfg.num_sms;
    tgt_prod    = 18'(sms1 * occ_r);
    quo_sat_chk = div_quo >> 16;
    advise_c    = (cost_sum_r != 42'd0) && (count_r >= CNT_W'(2)) &&
                  ((skew_r >= cfg.skew_thr) || (occ_r < best_r && pois_low_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cost_r <= in_op_cost;
      need_r <= in_shared_need;
      cap_r  <= in_block_cap;
      blk_r  <= in_assigned_blocks;
      last_r <= in_last_op;
    end
    if (cmd.mul) begin
      prod_a_r <= cost_r * worst_blk_r;
      prod_b_r <= worst_cost_r * blk_r;
    end
    if (cmd.div_store) begin
      unique case (cmd.sel)
        DSEL_OCC:  occ_r <= per;
        DSEL_BEST: best_r <= (per < occ_r) ? occ_r : per;
        DSEL_SKEW: begin
          if (cost_sum_r == 42'd0)        skew_r <= '0;
          else if (quo_sat_chk != '0)     skew_r <= '1;
          else                            skew_r <= div_quo[15:0];
        end
        DSEL_POIS: begin
          if (cost_sum_r == 42'd0)        pois_r <= '0;
          else if (quo_sat_chk != '0)     pois_r <= '1;
          else                            pois_r <= div_quo[15:0];
          pois_low_r <= ((div_quo >> 14) == '0);
        end
        default: ;
      endcase
    end
    if (cmd.tgt) tgt_r <= tgt_prod[17] ? '1 : tgt_prod[16:0];
    if (cmd.mul1) begin
      skew_num_r <= worst_cost_r * tgt_r;
      den_lo_r   <= worst_blk_r * cost_sum_r[20:0];
    end
    if (cmd.mul2) den_hi_r <= worst_blk_r * cost_sum_r[41:21];
    if (cmd.emit) begin
      op_total_r    <= count_r;
      blocks_out_r  <= block_sum_r;
      occ_out_r     <= occ_r;
      best_out_r    <= best_r;
      tgt_out_r     <= tgt_r;
      starved_out_r <= starved_r;
      skew_out_r    <= skew_r;
      pois_out_r    <= pois_r;
      advise_r      <= advise_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      count_r      <= '0;
      cost_sum_r   <= '0;
      block_sum_r  <= '0;
      largest_r    <= '0;
      smallest_r   <= '1;
      heavy_r      <= '0;
      worst_cost_r <= '0;
      worst_blk_r  <= 16'd1;
      starved_r    <= '0;
    end else if (cmd.upd) begin
      count_r      <= count_nxt;
      cost_sum_r   <= cost_sum_nxt;
      block_sum_r  <= block_sum_nxt;
      largest_r    <= largest_nxt;
      smallest_r   <= smallest_nxt;
      heavy_r      <= heavy_nxt;
      worst_cost_r <= worst_cost_nxt;
      worst_blk_r  <= worst_blk_nxt;
      starved_r    <= starved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.last     = last_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid              = out_valid_r;
  assign out_op_total           = op_total_r;
  assign out_blocks_total       = blocks_out_r;
  assign out_step_occupancy     = occ_out_r;
  assign out_best_occupancy     = best_out_r;
  assign out_target_block_count = tgt_out_r;
  assign out_starved_count      = starved_out_r;
  assign out_skew_ratio         = skew_out_r;
  assign out_poison_share       = pois_out_r;
  assign out_advise_partition   = advise_r;

endmodule
`default_nettype wire

### rtl/core/launch_grid_stats_top.sv
// Top level: configuration registers, sequencer and datapath.
`default_nettype none
// Launch grid statistics. Each transaction describes one operation of a step;
// an ordinary transaction passes through accept, product and update before the
// next one is taken. The transaction marked last also runs the end-of-step
// work on one shared 58-bit restoring divider, one quotient bit per cycle,
// four times (two occupancies, skew, poison share); its result is held back
// while an earlier result still waits in the output register. A finished
// result waits in the output register while the next step's transactions are
// taken. Configuration registers sit at byte addresses 4*i; the user must
// write them only while the block is idle, which the block does not enforce.
module launch_grid_stats_top
  import lgs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_op_cost,
  input  wire logic [17:0]        in_shared_need,
  input  wire logic [15:0]        in_block_cap,
  input  wire logic [15:0]        in_assigned_blocks,
  input  wire logic               in_last_op,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [10:0]             out_op_total,
  output logic [25:0]             out_blocks_total,
  output logic [6:0]              out_step_occupancy,
  output logic [6:0]              out_best_occupancy,
  output logic [16:0]             out_target_block_count,
  output logic [10:0]             out_starved_count,
  output logic [15:0]             out_skew_ratio,
  output logic [15:0]             out_poison_share,
  output logic                    out_advise_partition
);

  cfg_t     cfg_r;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_sms   <= 11'd1;
      cfg_r.max_blk   <= 7'd1;
      cfg_r.shared_sm <= '0;
      cfg_r.static_sh <= '0;
      cfg_r.skew_thr  <= 16'd256;
    end else if (wr_en) begin
      case (idx)
        REG_NUM_SMS:  cfg_r.num_sms   <= pwdata[10:0];
        REG_MAX_BLK:  cfg_r.max_blk   <= pwdata[6:0];
        REG_SHARED:   cfg_r.shared_sm <= pwdata[17:0];
        REG_STATIC:   cfg_r.static_sh <= pwdata[15:0];
        REG_SKEW_THR: cfg_r.skew_thr  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUM_SMS:  prdata = 32'(cfg_r.num_sms);
      REG_MAX_BLK:  prdata = 32'(cfg_r.max_blk);
      REG_SHARED:   prdata = 32'(cfg_r.shared_sm);
      REG_STATIC:   prdata = 32'(cfg_r.static_sh);
      REG_SKEW_THR: prdata = 32'(cfg_r.skew_thr);
      default:      prdata = '0;
    endcase
  end

  lgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lgs_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_op_cost             (in_op_cost),
    .in_shared_need         (in_shared_need),
    .in_block_cap           (in_block_cap),
    .in_assigned_blocks     (in_assigned_blocks),
    .in_last_op             (in_last_op),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_op_total           (out_op_total),
    .out_blocks_total       (out_blocks_total),
    .out_step_occupancy     (out_step_occupancy),
    .out_best_occupancy     (out_best_occupancy),
    .out_target_block_count (out_target_block_count),
    .out_starved_count      (out_starved_count),
    .out_skew_ratio         (out_skew_ratio),
    .out_poison_share       (out_poison_share),
    .out_advise_partition   (out_advise_partition)
  );

endmodule
`default_nettype wire
